// ===== hw/rtl/mode_method_binarizer_unit_assert.svh =====
// Assertion macros for the mode-method binarizer.
`ifndef MODE_METHOD_BINARIZER_UNIT_ASSERT_SVH
`define MODE_METHOD_BINARIZER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MMB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define MMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMB_ASSERT_NOW(label, clk, rst, ante, cons)
`define MMB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/mmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mmb_pkg;

   localparam int COUNT_BITS = 20;
   localparam int BIN_BITS   = 8;
   localparam int BINS       = 1 << BIN_BITS;
   localparam int CUT_W      = 20;
   localparam int PASS_W     = 3;
   localparam int THR_W      = 9;
   localparam int PIX_W      = 8;
   localparam int SUM_BITS   = COUNT_BITS + 2;
   localparam int CMP_W      = (COUNT_BITS > CUT_W) ? COUNT_BITS : CUT_W;

   // floor(2^SUM_BITS / 3): reciprocal for the divide by three
   localparam logic [SUM_BITS-1:0] DIV3_MUL = SUM_BITS'(((64'd1) << SUM_BITS) / 64'd3);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [CUT_W-1:0]      CUT_RESET  = CUT_W'(3000);
   localparam logic [PASS_W-1:0]     PASS_RESET = PASS_W'(3);
   localparam logic [PIX_W-1:0]      WHITE      = PIX_W'(255);
   localparam logic [PIX_W-1:0]      BLACK      = '0;
   localparam logic [BIN_BITS-1:0]   LAST_INNER = BIN_BITS'(BINS - 2);
   localparam logic [BIN_BITS-1:0]   LAST_BIN   = BIN_BITS'(BINS - 1);

   // register indexes
   localparam logic CSR_CUT_LEVEL     = 1'b0;
   localparam logic CSR_SMOOTH_PASSES = 1'b1;

   // result kinds
   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_BIN   = 1'b1;

   typedef struct packed {
      logic [BIN_BITS-1:0]   rd_addr;
      logic                  wr_en;
      logic [BIN_BITS-1:0]   wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
      logic                  clr;
   } mem_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [THR_W-1:0] thr;
      logic                    found;
   } thr_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SM_R0,
      ST_SM_R1,
      ST_SM_C1,
      ST_SM_RN,
      ST_SM_SUM,
      ST_SM_MUL,
      ST_SM_FIX,
      ST_CT_RD,
      ST_CT_EV,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mmb_hist_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mmb_hist_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mmb_pkg::mem_req_type          req,
   output logic [mmb_pkg::COUNT_BITS-1:0]     rd_data
);
   import mmb_pkg::*;

   logic [COUNT_BITS-1:0] mem_ff [BINS];
   logic [BINS-1:0]       valid_ff;
   logic [COUNT_BITS-1:0] q_ff;
   logic                  qv_ff;

   // storage, read before write
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      q_ff  <= mem_ff[req.rd_addr];
      qv_ff <= valid_ff[req.rd_addr];
   end

   // per-bin valid bits; a bin never written since the last clear reads zero
   always_ff @(posedge clock) begin
      if (reset || req.clr) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/mmb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mmb_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start_calc,
   input  wire logic [mmb_pkg::CUT_W-1:0]     cut_level,
   input  wire logic [mmb_pkg::PASS_W-1:0]    smooth_passes,
   input  wire logic [mmb_pkg::COUNT_BITS-1:0] rd_data,
   output mmb_pkg::mem_req_type               req,
   output logic                               active,
   output mmb_pkg::thr_res_type               res
);
   import mmb_pkg::*;

   state_type state_ff, state_in;

   logic [BIN_BITS-1:0]   idx_ff;
   logic [PASS_W-1:0]     pass_ff;
   logic [COUNT_BITS-1:0] prev_ff, cur_ff;
   logic [SUM_BITS-1:0]   sum_ff, q0_ff;
   logic                  prevcut_ff;
   logic [BIN_BITS-1:0]   t1_ff, t2_ff;
   logic                  t1f_ff, t2f_ff;

   logic [2*SUM_BITS-1:0] prod;
   logic [SUM_BITS-1:0]   rem;
   logic [COUNT_BITS-1:0] q;
   logic                  last_pass;
   logic                  cut_bit;
   logic signed [THR_W:0] t1v, t2v, tsum;

   assign last_pass = ({1'b0, pass_ff} + (PASS_W+1)'(1)) == {1'b0, smooth_passes};
   assign cut_bit   = CMP_W'(rd_data) > CMP_W'(cut_level);

   // divide by three: reciprocal product, then one correction step
   assign prod = (2*SUM_BITS)'(sum_ff) * (2*SUM_BITS)'(DIV3_MUL);
   assign rem  = sum_ff - ((q0_ff << 1) + q0_ff);
   assign q    = (rem >= SUM_BITS'(3)) ? COUNT_BITS'(q0_ff + SUM_BITS'(1))
                                       : COUNT_BITS'(q0_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_calc) begin
               state_in = (smooth_passes == '0) ? ST_CT_RD : ST_SM_R0;
            end
         end
         ST_SM_R0:  state_in = ST_SM_R1;
         ST_SM_R1:  state_in = ST_SM_C1;
         ST_SM_C1:  state_in = ST_SM_RN;
         ST_SM_RN:  state_in = ST_SM_SUM;
         ST_SM_SUM: state_in = ST_SM_MUL;
         ST_SM_MUL: state_in = ST_SM_FIX;
         ST_SM_FIX: begin
            if (idx_ff == LAST_INNER) begin
               state_in = last_pass ? ST_CT_RD : ST_SM_R0;
            end else begin
               state_in = ST_SM_RN;
            end
         end
         ST_CT_RD:  state_in = ST_CT_EV;
         ST_CT_EV:  state_in = (idx_ff == LAST_BIN) ? ST_DONE : ST_CT_RD;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory requests per state
   always_comb begin
      req.rd_addr = idx_ff;
      req.wr_en   = 1'b0;
      req.wr_addr = idx_ff;
      req.wr_data = q;
      req.clr     = 1'b0;
      case (state_ff)
         ST_SM_R0:  req.rd_addr = '0;
         ST_SM_R1:  req.rd_addr = BIN_BITS'(1);
         ST_SM_RN:  req.rd_addr = idx_ff + BIN_BITS'(1);
         ST_SM_FIX: req.wr_en   = 1'b1;
         ST_DONE:   req.clr     = 1'b1;
         default:   req.wr_en   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // smoothing and valley scan datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            idx_ff  <= '0;
            pass_ff <= '0;
            t1f_ff  <= 1'b0;
            t2f_ff  <= 1'b0;
         end
         ST_SM_R1: prev_ff <= rd_data;
         ST_SM_C1: begin
            cur_ff <= rd_data;
            idx_ff <= BIN_BITS'(1);
         end
         ST_SM_SUM: begin
            sum_ff <= SUM_BITS'(prev_ff) + SUM_BITS'(cur_ff) + SUM_BITS'(rd_data);
            cur_ff <= rd_data;
         end
         ST_SM_MUL: q0_ff <= prod[2*SUM_BITS-1:SUM_BITS];
         ST_SM_FIX: begin
            prev_ff <= q;
            if (idx_ff == LAST_INNER) begin
               idx_ff  <= '0;
               pass_ff <= pass_ff + PASS_W'(1);
            end else begin
               idx_ff <= idx_ff + BIN_BITS'(1);
            end
         end
         ST_CT_EV: begin
            prevcut_ff <= cut_bit;
            idx_ff     <= idx_ff + BIN_BITS'(1);
            if (idx_ff != '0 && !t2f_ff) begin
               if (prevcut_ff && !cut_bit) begin
                  t1_ff  <= idx_ff;
                  t1f_ff <= 1'b1;
               end else if (!prevcut_ff && cut_bit && t1f_ff) begin
                  t2_ff  <= idx_ff;
                  t2f_ff <= 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // threshold: mean of the edges, minus one for a missing edge
   assign t1v  = t1f_ff ? $signed({2'b00, t1_ff}) : -(THR_W+1)'(1);
   assign t2v  = t2f_ff ? $signed({2'b00, t2_ff}) : -(THR_W+1)'(1);
   assign tsum = t1v + t2v;

   assign active    = (state_ff != ST_IDLE);
   assign res.done  = (state_ff == ST_DONE);
   assign res.thr   = THR_W'(tsum >>> 1);
   assign res.found = t1f_ff && t2f_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mode_method_binarizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "mode_method_binarizer_unit_assert.svh"
// Mode-method binarizer: threshold from the valley of a gray-level histogram.
// Command channel: an item transfers when start is high and busy is low.
// req_kind 0 counts req_pixel into the histogram, one pixel per cycle while
// busy is low; a read-modify-write of the histogram memory with forwarding of
// the last write. With req_frame_end set, busy rises the following cycle and
// the block smooths the histogram smooth_passes times, cuts and scans it, then
// issues the threshold report on the rsp_ ports; the histogram is cleared as
// the report is issued. req_kind 1 binarizes req_pixel against the stored
// threshold, one per cycle while busy is low; its result appears in the cycle
// after the transfer. Results are shown for one cycle with rsp_strobe; the
// receiver cannot stall. The csr_ port writes cut_level (index 0) and
// smooth_passes (index 1); the user must write them only while idle, which the
// block itself does not enforce. Reset: empty histogram, threshold -1,
// cut_level 3000, 3 passes.
module mode_method_binarizer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_kind,
   input  wire logic [mmb_pkg::PIX_W-1:0]         req_pixel,
   input  wire logic                              req_frame_end,
   output logic                                   rsp_strobe,
   output logic                                   rsp_result_kind,
   output logic [mmb_pkg::PIX_W-1:0]              rsp_out_pixel,
   output logic signed [mmb_pkg::THR_W-1:0]       rsp_threshold,
   output logic                                   rsp_valley_found,
   input  wire logic                              csr_write_en,
   input  wire logic                              csr_index,
   input  wire logic [mmb_pkg::CUT_W-1:0]         csr_wdata
);
   import mmb_pkg::*;

   logic [CUT_W-1:0]        cut_ff;
   logic [PASS_W-1:0]       passes_ff;
   logic                    s1_valid_ff, s1_fend_ff;
   logic [BIN_BITS-1:0]     s1_addr_ff;
   logic                    lw_valid_ff;
   logic [BIN_BITS-1:0]     lw_addr_ff;
   logic [COUNT_BITS-1:0]   lw_data_ff;
   logic signed [THR_W-1:0] thr_ff;
   logic                    rsp_valid_ff, rsp_kind_ff, rsp_found_ff;
   logic [PIX_W-1:0]        rsp_pix_ff;
   logic signed [THR_W-1:0] rsp_thr_ff;

   logic                    accept;
   logic                    start_calc;
   logic                    ctrl_active;
   logic [COUNT_BITS-1:0]   rd_data, old_cnt, new_cnt;
   mem_req_type             ctrl_req, mem_req;
   thr_res_type             ctrl_res;

   assign start_calc = s1_valid_ff && s1_fend_ff;
   assign busy       = ctrl_active || start_calc;
   assign accept     = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff    <= CUT_RESET;
         passes_ff <= PASS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CUT_LEVEL:     cut_ff    <= csr_wdata;
            CSR_SMOOTH_PASSES: passes_ff <= PASS_W'(csr_wdata);
            default:           cut_ff    <= cut_ff;
         endcase
      end
   end

   // counting stage: read issued at transfer, write back in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (req_kind == KIND_COUNT);
         lw_valid_ff <= s1_valid_ff;
      end
      s1_addr_ff <= req_pixel;
      s1_fend_ff <= req_frame_end;
      lw_addr_ff <= s1_addr_ff;
      lw_data_ff <= new_cnt;
   end

   // forward the previous write on a repeated bin; saturating increment
   assign old_cnt = (lw_valid_ff && lw_addr_ff == s1_addr_ff) ? lw_data_ff : rd_data;
   assign new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_BITS'(1);

   always_comb begin
      if (ctrl_active) begin
         mem_req = ctrl_req;
      end else begin
         mem_req.rd_addr = req_pixel;
         mem_req.wr_en   = s1_valid_ff;
         mem_req.wr_addr = s1_addr_ff;
         mem_req.wr_data = new_cnt;
         mem_req.clr     = 1'b0;
      end
   end

   mmb_hist_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .rd_data (rd_data)
   );

   mmb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start_calc    (start_calc),
      .cut_level     (cut_ff),
      .smooth_passes (passes_ff),
      .rd_data       (rd_data),
      .req           (ctrl_req),
      .active        (ctrl_active),
      .res           (ctrl_res)
   );

   // stored threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= -THR_W'(1);
      end else if (ctrl_res.done) begin
         thr_ff <= ctrl_res.thr;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_res.done || (accept && req_kind == KIND_BIN);
      end
      if (ctrl_res.done) begin
         rsp_kind_ff  <= KIND_COUNT;
         rsp_pix_ff   <= BLACK;
         rsp_thr_ff   <= ctrl_res.thr;
         rsp_found_ff <= ctrl_res.found;
      end else begin
         rsp_kind_ff  <= KIND_BIN;
         rsp_pix_ff   <= ($signed({1'b0, req_pixel}) <= thr_ff) ? BLACK : WHITE;
         rsp_thr_ff   <= thr_ff;
         rsp_found_ff <= 1'b0;
      end
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_out_pixel    = rsp_pix_ff;
   assign rsp_threshold    = rsp_thr_ff;
   assign rsp_valley_found = rsp_found_ff;

   `MMB_ASSERT_NEXT(a_done_reports, clock, reset, ctrl_res.done, rsp_strobe && rsp_result_kind == KIND_COUNT)
   `MMB_ASSERT_NEXT(a_bin_result, clock, reset, accept && req_kind == KIND_BIN, rsp_strobe && rsp_result_kind == KIND_BIN)
   `MMB_ASSERT_NOW(a_valley_positive, clock, reset, rsp_strobe && rsp_valley_found, !rsp_threshold[THR_W-1])
   `MMB_ASSERT_NOW(a_no_count_in_calc, clock, reset, ctrl_active, !s1_valid_ff)

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import mmb_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int SETTLE      = 20;
   localparam int ITEM_TARGET = 1700;

   // one predicted result
   typedef struct {
      logic                    kind;
      logic [PIX_W-1:0]        pixel;
      logic signed [THR_W-1:0] thr;
      logic                    found;
   } outcome_type;

   // histogram predictor and store of pending results
   class binarizer_scoreboard;
      longint unsigned         hist[BINS];
      longint unsigned         cut_level;
      int unsigned             passes;
      logic signed [THR_W-1:0] thr_held;
      outcome_type             pending[$];
      int                      errors;

      function new();
         foreach (hist[i]) hist[i] = 0;
         cut_level = 3000;
         passes    = 3;
         thr_held  = -1;
         errors    = 0;
      endfunction

      function void set_reg(logic idx, logic [CUT_W-1:0] val);
         if (idx == CSR_CUT_LEVEL) cut_level = val;
         else passes = val[PASS_W-1:0];
      endfunction

      // accepted transfer on the command side
      function void note_input(logic kind, logic [PIX_W-1:0] pix, logic fe);
         outcome_type o;
         logic        cut[BINS];
         int          t1, t2, t;
         if (kind == KIND_BIN) begin
            o.kind  = KIND_BIN;
            o.pixel = ($signed({1'b0, pix}) <= thr_held) ? BLACK : WHITE;
            o.thr   = thr_held;
            o.found = 1'b0;
            pending.push_back(o);
            return;
         end
         if (hist[pix] < longint'(COUNT_MAX)) hist[pix]++;
         if (!fe) return;
         for (int p = 0; p < passes; p++)
            for (int j = 1; j < BINS - 1; j++)
               hist[j] = (hist[j-1] + hist[j] + hist[j+1]) / 3;
         foreach (cut[j]) cut[j] = (hist[j] > cut_level);
         t1 = -1;
         t2 = -1;
         for (int j = 1; j < BINS; j++) begin
            if (cut[j-1] && !cut[j]) t1 = j;
            else if (!cut[j-1] && cut[j] && t1 != -1) begin
               t2 = j;
               break;
            end
         end
         t        = (t1 + t2) / 2;
         thr_held = t;
         o.kind   = KIND_COUNT;
         o.pixel  = BLACK;
         o.thr    = t;
         o.found  = (t1 != -1 && t2 != -1);
         pending.push_back(o);
         foreach (hist[i]) hist[i] = 0;
      endfunction

      // result strobe seen
      function void check_result(logic kind, logic [PIX_W-1:0] pix,
                                 logic signed [THR_W-1:0] thr, logic found);
         outcome_type o;
         if (pending.size() == 0) begin
            $display("%0t unexpected result kind=%0d pixel=%0d thr=%0d", $time,
                     kind, pix, thr);
            errors++;
            return;
         end
         o = pending.pop_front();
         if (kind !== o.kind) begin
            $display("%0t result_kind exp %0d got %0d", $time, o.kind, kind);
            errors++;
         end
         if (pix !== o.pixel) begin
            $display("%0t out_pixel exp %0d got %0d", $time, o.pixel, pix);
            errors++;
         end
         if (thr !== o.thr) begin
            $display("%0t threshold exp %0d got %0d", $time, o.thr, thr);
            errors++;
         end
         if (found !== o.found) begin
            $display("%0t valley_found exp %0d got %0d", $time, o.found, found);
            errors++;
         end
      endfunction
   endclass

   logic                    clock, reset, start, busy;
   logic                    req_kind, req_frame_end;
   logic [PIX_W-1:0]        req_pixel;
   logic                    rsp_strobe, rsp_result_kind, rsp_valley_found;
   logic [PIX_W-1:0]        rsp_out_pixel;
   logic signed [THR_W-1:0] rsp_threshold;
   logic                    csr_write_en, csr_index;
   logic [CUT_W-1:0]        csr_wdata;

   binarizer_scoreboard sb;
   int  idle_cycles;
   int  items_sent;
   bit  no_gaps;

   mode_method_binarizer_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_pixel(req_pixel), .req_frame_end(req_frame_end),
      .rsp_strobe(rsp_strobe), .rsp_result_kind(rsp_result_kind),
      .rsp_out_pixel(rsp_out_pixel), .rsp_threshold(rsp_threshold),
      .rsp_valley_found(rsp_valley_found), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // monitor: transfers in, results out, stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result(rsp_result_kind, rsp_out_pixel, rsp_threshold,
                            rsp_valley_found);
         if (start && !busy) sb.note_input(req_kind, req_pixel, req_frame_end);
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(logic idx, logic [CUT_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   // one command transfer; start stays high when the next one follows at once
   task automatic send(logic kind, logic [PIX_W-1:0] pix, logic fe);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_pixel     <= pix;
      req_frame_end <= fe;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // hold off until every result is in, then let the block settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // a frame of two clusters of grey levels, or plain noise, with an occasional binarize item
   task automatic random_frame();
      int n, c1, c2, spread;
      bit noise;
      n      = $urandom_range(4, 40);
      c1     = $urandom_range(0, 110);
      c2     = $urandom_range(140, 255);
      spread = $urandom_range(0, 4);
      noise  = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n; i++) begin
         int p;
         if (noise) p = $urandom_range(0, 255);
         else if ($urandom_range(0, 1)) p = c1 + $urandom_range(0, spread);
         else p = c2 - $urandom_range(0, spread);
         if ($urandom_range(0, 15) == 0)
            send(KIND_BIN, $urandom_range(0, 255), $urandom_range(0, 1));
         send(KIND_COUNT, p, i == n - 1);
      end
   endtask

   initial begin
      sb            = new();
      idle_cycles   = 0;
      items_sent    = 0;
      no_gaps       = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_COUNT;
      req_pixel     = '0;
      req_frame_end = 1'b0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_CUT_LEVEL;
      csr_wdata     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // binarizing before any frame, and frame end on a binarize item
      send(KIND_BIN, 8'd0, 1'b0);
      send(KIND_BIN, 8'd255, 1'b0);
      send(KIND_BIN, 8'd7, 1'b1);
      drain();
      // clean two-peak frame without smoothing
      csr_write(CSR_CUT_LEVEL, '0);
      csr_write(CSR_SMOOTH_PASSES, '0);
      send(KIND_COUNT, 8'd10, 1'b0);
      send(KIND_COUNT, 8'd10, 1'b0);
      send(KIND_COUNT, 8'd200, 1'b1);
      send(KIND_BIN, 8'd105, 1'b0);
      send(KIND_BIN, 8'd106, 1'b0);
      send(KIND_BIN, 8'd254, 1'b0);
      drain();
      // only the falling edge; then neither edge
      send(KIND_COUNT, 8'd0, 1'b1);
      send(KIND_BIN, 8'd0, 1'b0);
      drain();
      send(KIND_COUNT, 8'd255, 1'b1);
      send(KIND_BIN, 8'd255, 1'b0);
      drain();
      // largest cut level and most passes
      csr_write(CSR_CUT_LEVEL, {CUT_W{1'b1}});
      csr_write(CSR_SMOOTH_PASSES, 3'd7);
      send(KIND_COUNT, 8'd128, 1'b0);
      send(KIND_COUNT, 8'd128, 1'b1);
      send(KIND_BIN, 8'd0, 1'b0);
      drain();

      // random frames, each followed by some binarizing
      while (items_sent < ITEM_TARGET) begin
         int nb;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(CSR_CUT_LEVEL, $urandom_range(0, 1048575));
               1: csr_write(CSR_CUT_LEVEL, $urandom_range(0, 30));
               default: csr_write(CSR_CUT_LEVEL, $urandom_range(0, 2));
            endcase
            if ($urandom_range(0, 9) == 0)
               csr_write(CSR_SMOOTH_PASSES, $urandom_range(0, 7));
            else
               csr_write(CSR_SMOOTH_PASSES, $urandom_range(0, 1));
         end
         no_gaps = ($urandom_range(0, 2) == 0);
         random_frame();
         nb = $urandom_range(5, 25);
         for (int i = 0; i < nb; i++)
            send(KIND_BIN, $urandom_range(0, 255), $urandom_range(0, 1));
         drain();
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mmb_pkg.sv
hw/rtl/mmb_hist_mem.sv
hw/rtl/mmb_ctrl.sv
hw/rtl/mode_method_binarizer_unit.sv
bench/tb.sv
